// ----- rtl/rbi_pkg.sv -----
// Shared types, widths and constants for the ray versus box intersection block.
// Used by the pipelined divider and the top level; depends on nothing else.
`default_nettype none

package rbi_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  // Quotient bits resolved by the divider, and its internal widths.
  localparam int QB      = COORD_WIDTH + 1;
  localparam int NW      = COORD_WIDTH + 1 + FRAC_BITS;
  localparam int RW      = COORD_WIDTH + 1;
  localparam int CMPW    = (FRAC_BITS > RW) ? FRAC_BITS : RW;
  localparam int DIV_LAT = QB + 2;

  // Product and saturating-sum widths for the hit point.
  localparam int PW = 2 * COORD_WIDTH;
  localparam int SW = PW + 1;

  localparam int CFG_IDX_W = 3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [COORD_WIDTH:0]   diff_t;
  typedef logic        [COORD_WIDTH-2:0] dist_t;
  typedef logic        [CFG_IDX_W-1:0]   cfg_idx_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  localparam cfg_idx_t REG_MIN_X = 3'd0;
  localparam cfg_idx_t REG_MIN_Y = 3'd1;
  localparam cfg_idx_t REG_MIN_Z = 3'd2;
  localparam cfg_idx_t REG_MAX_X = 3'd3;
  localparam cfg_idx_t REG_MAX_Y = 3'd4;
  localparam cfg_idx_t REG_MAX_Z = 3'd5;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  typedef struct packed {
    coord_t [2:0] o;
    coord_t [2:0] d;
    dist_t        nearest;
    logic         from_in;
    logic   [2:0] inv;
    logic   [2:0] inr;
  } side_t;

endpackage

`default_nettype wire

// ----- rtl/rbi_div.sv -----
// Fully pipelined signed fixed-point divider: (num << FRAC_BITS) / den, truncated
// toward zero and saturated to the coordinate range. Depends on rbi_pkg.
`default_nettype none

module rbi_div (
  input  logic           clk,
  input  rbi_pkg::diff_t num,
  input  rbi_pkg::coord_t den,
  output rbi_pkg::coord_t quo
);
  import rbi_pkg::*;

  localparam logic [QB-1:0] POS_LIM = {2'b00, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [QB-1:0] NEG_LIM = {2'b01, {(COORD_WIDTH-1){1'b0}}};

  logic [COORD_WIDTH:0]   num_mag;
  logic [COORD_WIDTH-1:0] den_mag;
  logic [NW-1:0]          a_full;
  logic [CMPW-1:0]        hi_ext;
  logic [CMPW-1:0]        b_ext;
  logic                   ovf0;

  logic [RW-1:0]          rem_r [0:QB];
  logic [QB-1:0]          lo_r  [0:QB];
  logic [COORD_WIDTH-1:0] b_r   [0:QB];
  logic                   neg_r [0:QB];
  logic                   ovf_r [0:QB];

  coord_t quo_nxt;
  coord_t quo_r;

  assign num_mag = num[COORD_WIDTH] ? (~num + 1'b1) : num;
  assign den_mag = den[COORD_WIDTH-1] ? (~den + 1'b1) : den;
  assign a_full  = {num_mag, {FRAC_BITS{1'b0}}};
  assign hi_ext  = CMPW'(a_full[NW-1:QB]);
  assign b_ext   = CMPW'(den_mag);
  assign ovf0    = hi_ext >= b_ext;

  always_ff @(posedge clk) begin
    rem_r[0] <= ovf0 ? '0 : hi_ext[RW-1:0];
    lo_r[0]  <= a_full[QB-1:0];
    b_r[0]   <= den_mag;
    neg_r[0] <= num[COORD_WIDTH] ^ den[COORD_WIDTH-1];
    ovf_r[0] <= ovf0;
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [RW-1:0] trial;
    logic          take;
    logic [RW-1:0] rem_nxt;

    assign trial   = {rem_r[k][RW-2:0], lo_r[k][QB-1]};
    assign take    = trial >= RW'(b_r[k]);
    assign rem_nxt = take ? (trial - RW'(b_r[k])) : trial;

    always_ff @(posedge clk) begin
      rem_r[k+1] <= rem_nxt;
      lo_r[k+1]  <= {lo_r[k][QB-2:0], take};
      b_r[k+1]   <= b_r[k];
      neg_r[k+1] <= neg_r[k];
      ovf_r[k+1] <= ovf_r[k];
    end
  end

  always_comb begin
    if (!neg_r[QB]) begin
      if (ovf_r[QB] || lo_r[QB] > POS_LIM) begin
        quo_nxt = COORD_MAX;
      end else begin
        quo_nxt = coord_t'(lo_r[QB][COORD_WIDTH-1:0]);
      end
    end else begin
      if (ovf_r[QB] || lo_r[QB] > NEG_LIM) begin
        quo_nxt = COORD_MIN;
      end else begin
        quo_nxt = coord_t'(~lo_r[QB][COORD_WIDTH-1:0] + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
  end

  assign quo = quo_r;

endmodule

`default_nettype wire

// ----- rtl/ray_box_intersect_top.sv -----
// Ray versus axis-aligned box test: front end, six pipelined dividers and the
// selection, hit point and output stages. Depends on rbi_pkg and rbi_div.
//
// The block takes one ray in every cycle and never asserts busy. Each result
// appears on the out_ ports, marked by out_valid, once its ray has passed the
// front-end register, the 33-step restoring divider pipeline that computes the
// six plane distances, and stages P1 to P4.
`default_nettype none

module ray_box_intersect_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  rbi_pkg::cfg_idx_t cfg_index,
  input  rbi_pkg::coord_t   cfg_data,
  input  logic              start,
  output logic              busy,
  input  rbi_pkg::coord_t   in_origin_x,
  input  rbi_pkg::coord_t   in_origin_y,
  input  rbi_pkg::coord_t   in_origin_z,
  input  rbi_pkg::coord_t   in_dir_x,
  input  rbi_pkg::coord_t   in_dir_y,
  input  rbi_pkg::coord_t   in_dir_z,
  input  rbi_pkg::dist_t    in_nearest_so_far,
  input  logic              in_from_inside,
  output logic              out_valid,
  output logic              out_hit,
  output rbi_pkg::dist_t    out_hit_dist,
  output rbi_pkg::coord_t   out_hit_x,
  output rbi_pkg::coord_t   out_hit_y,
  output rbi_pkg::coord_t   out_hit_z,
  output logic [1:0]        out_normal_axis,
  output logic              out_normal_negative
);
  import rbi_pkg::*;

  localparam int OUT_LAT = DIV_LAT + 4;

  coord_t box_lo_r [3];
  coord_t box_hi_r [3];

  coord_t in_o [3];
  coord_t in_d [3];
  coord_t bl [3];
  coord_t bh [3];
  logic   inv_nxt [3];
  logic   inr_nxt [3];

  diff_t  n_lo_r [3];
  diff_t  n_hi_r [3];
  side_t  side_s1_r;
  logic   vld_s1_r;

  coord_t q_lo [3];
  coord_t q_hi [3];

  side_t  side_dl_r [0:DIV_LAT-1];
  logic   vld_dl_r  [0:DIV_LAT-1];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        box_lo_r[a] <= '0;
        box_hi_r[a] <= coord_t'(1) <<< FRAC_BITS;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_X: box_lo_r[0] <= cfg_data;
        REG_MIN_Y: box_lo_r[1] <= cfg_data;
        REG_MIN_Z: box_lo_r[2] <= cfg_data;
        REG_MAX_X: box_hi_r[0] <= cfg_data;
        REG_MAX_Y: box_hi_r[1] <= cfg_data;
        REG_MAX_Z: box_hi_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end: order the bounds and form the plane offsets.
  assign in_o[0] = in_origin_x;
  assign in_o[1] = in_origin_y;
  assign in_o[2] = in_origin_z;
  assign in_d[0] = in_dir_x;
  assign in_d[1] = in_dir_y;
  assign in_d[2] = in_dir_z;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      inv_nxt[a] = box_lo_r[a] > box_hi_r[a];
      bl[a]      = inv_nxt[a] ? box_hi_r[a] : box_lo_r[a];
      bh[a]      = inv_nxt[a] ? box_lo_r[a] : box_hi_r[a];
      inr_nxt[a] = !(in_o[a] < bl[a] || in_o[a] > bh[a]);
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      n_lo_r[a]         <= diff_t'(bl[a]) - diff_t'(in_o[a]);
      n_hi_r[a]         <= diff_t'(bh[a]) - diff_t'(in_o[a]);
      side_s1_r.o[a]    <= in_o[a];
      side_s1_r.d[a]    <= in_d[a];
      side_s1_r.inv[a]  <= inv_nxt[a];
      side_s1_r.inr[a]  <= inr_nxt[a];
    end
    side_s1_r.nearest <= in_nearest_so_far;
    side_s1_r.from_in <= in_from_inside;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_s1_r <= 1'b0;
    end else begin
      vld_s1_r <= start && !busy;
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_div
    rbi_div u_div_lo (.clk(clk), .num(n_lo_r[a]), .den(side_s1_r.d[a]), .quo(q_lo[a]));
    rbi_div u_div_hi (.clk(clk), .num(n_hi_r[a]), .den(side_s1_r.d[a]), .quo(q_hi[a]));
  end

  always_ff @(posedge clk) begin
    side_dl_r[0] <= side_s1_r;
    for (int k = 1; k < DIV_LAT; k++) begin
      side_dl_r[k] <= side_dl_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        vld_dl_r[k] <= 1'b0;
      end
    end else begin
      vld_dl_r[0] <= vld_s1_r;
      for (int k = 1; k < DIV_LAT; k++) begin
        vld_dl_r[k] <= vld_dl_r[k-1];
      end
    end
  end

  // Stage P1: slab intervals and exit plane distances.
  side_t  side_p0;
  coord_t d0 [3];
  coord_t lo1_nxt [3];
  coord_t hi1_nxt [3];
  coord_t tex1_nxt [3];
  logic   miss1_nxt;

  coord_t lo1_r [3];
  coord_t hi1_r [3];
  coord_t tex1_r [3];
  logic   miss1_r;
  side_t  side1_r;
  logic   vld1_r;

  assign side_p0 = side_dl_r[DIV_LAT-1];

  always_comb begin
    miss1_nxt = 1'b0;
    for (int a = 0; a < 3; a++) begin
      d0[a] = side_p0.d[a];
      if (d0[a] == '0) begin
        lo1_nxt[a]  = COORD_MIN;
        hi1_nxt[a]  = COORD_MAX;
        tex1_nxt[a] = COORD_MAX;
        if (!side_p0.inr[a]) begin
          miss1_nxt = 1'b1;
        end
      end else begin
        lo1_nxt[a]  = (q_lo[a] > q_hi[a]) ? q_hi[a] : q_lo[a];
        hi1_nxt[a]  = (q_lo[a] > q_hi[a]) ? q_lo[a] : q_hi[a];
        tex1_nxt[a] = ((d0[a] > 0) ^ side_p0.inv[a]) ? q_hi[a] : q_lo[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      lo1_r[a]  <= lo1_nxt[a];
      hi1_r[a]  <= hi1_nxt[a];
      tex1_r[a] <= tex1_nxt[a];
    end
    miss1_r <= miss1_nxt;
    side1_r <= side_p0;
  end

  // Stage P2: entry distance or exit plane, and the face axis.
  coord_t tmax;
  logic   bad;
  axis_t  ax_en;
  axis_t  ax_ex;
  coord_t t2_nxt;
  axis_t  axis2_nxt;
  logic   hitp2_nxt;

  coord_t t2_r;
  axis_t  axis2_r;
  logic   hitp2_r;
  side_t  side2_r;
  logic   vld2_r;

  always_comb begin
    tmax = lo1_r[0];
    if (lo1_r[1] > tmax) begin
      tmax = lo1_r[1];
    end
    if (lo1_r[2] > tmax) begin
      tmax = lo1_r[2];
    end
    bad = lo1_r[0] > hi1_r[1] || lo1_r[1] > hi1_r[0] || lo1_r[2] > hi1_r[1] ||
          lo1_r[2] > hi1_r[0] || lo1_r[0] > hi1_r[2] || lo1_r[1] > hi1_r[2];
    if (tmax == lo1_r[0]) begin
      ax_en = AXIS_X;
    end else if (tmax == lo1_r[1]) begin
      ax_en = AXIS_Y;
    end else begin
      ax_en = AXIS_Z;
    end
    if (tex1_r[0] < tex1_r[1] && tex1_r[0] < tex1_r[2]) begin
      ax_ex = AXIS_X;
    end else if (tex1_r[1] < tex1_r[2]) begin
      ax_ex = AXIS_Y;
    end else begin
      ax_ex = AXIS_Z;
    end
    if (side1_r.from_in) begin
      axis2_nxt = ax_ex;
      hitp2_nxt = 1'b1;
      case (ax_ex)
        AXIS_X:  t2_nxt = tex1_r[0];
        AXIS_Y:  t2_nxt = tex1_r[1];
        default: t2_nxt = tex1_r[2];
      endcase
    end else begin
      axis2_nxt = ax_en;
      hitp2_nxt = !miss1_r && !bad;
      t2_nxt    = tmax;
    end
  end

  always_ff @(posedge clk) begin
    t2_r    <= t2_nxt;
    axis2_r <= axis2_nxt;
    hitp2_r <= hitp2_nxt;
    side2_r <= side1_r;
  end

  // Stage P3: final hit decision and the three products dir * t.
  coord_t d2 [3];
  coord_t near2;
  coord_t d_axis;
  logic   hit3_nxt;

  logic signed [PW-1:0] prod3_r [3];
  coord_t o3_r [3];
  coord_t t3_r;
  axis_t  axis3_r;
  logic   neg3_r;
  logic   hit3_r;
  logic   vld3_r;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      d2[a] = side2_r.d[a];
    end
    near2 = coord_t'({1'b0, side2_r.nearest});
    case (axis2_r)
      AXIS_X:  d_axis = d2[0];
      AXIS_Y:  d_axis = d2[1];
      default: d_axis = d2[2];
    endcase
    if (side2_r.from_in) begin
      hit3_nxt = 1'b1;
    end else begin
      hit3_nxt = hitp2_r && !(t2_r > near2 || t2_r < 0);
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      prod3_r[a] <= d2[a] * t2_r;
      o3_r[a]    <= side2_r.o[a];
    end
    t3_r    <= t2_r;
    axis3_r <= axis2_r;
    neg3_r  <= d_axis > 0;
    hit3_r  <= hit3_nxt;
  end

  // Stage P4: hit point with floor scaling and saturation, output registers.
  logic signed [PW-1:0] qsh [3];
  logic signed [SW-1:0] psum [3];
  coord_t pt [3];

  coord_t out_x_r;
  coord_t out_y_r;
  coord_t out_z_r;
  dist_t  out_dist_r;
  logic   out_hit_r;
  logic [1:0] out_axis_r;
  logic   out_neg_r;
  logic   out_valid_r;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      qsh[a]  = prod3_r[a] >>> FRAC_BITS;
      psum[a] = SW'(qsh[a]) + SW'(o3_r[a]);
      if (psum[a] > SW'(COORD_MAX)) begin
        pt[a] = COORD_MAX;
      end else if (psum[a] < SW'(COORD_MIN)) begin
        pt[a] = COORD_MIN;
      end else begin
        pt[a] = psum[a][COORD_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit3_r) begin
      out_hit_r  <= 1'b1;
      out_dist_r <= (t3_r < 0) ? '0 : t3_r[COORD_WIDTH-2:0];
      out_x_r    <= pt[0];
      out_y_r    <= pt[1];
      out_z_r    <= pt[2];
      out_axis_r <= axis3_r;
      out_neg_r  <= neg3_r;
    end else begin
      out_hit_r  <= 1'b0;
      out_dist_r <= '0;
      out_x_r    <= '0;
      out_y_r    <= '0;
      out_z_r    <= '0;
      out_axis_r <= '0;
      out_neg_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r      <= 1'b0;
      vld2_r      <= 1'b0;
      vld3_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld1_r      <= vld_dl_r[DIV_LAT-1];
      vld2_r      <= vld1_r;
      vld3_r      <= vld2_r;
      out_valid_r <= vld3_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_hit             = out_hit_r;
  assign out_hit_dist        = out_dist_r;
  assign out_hit_x           = out_x_r;
  assign out_hit_y           = out_y_r;
  assign out_hit_z           = out_z_r;
  assign out_normal_axis     = out_axis_r;
  assign out_normal_negative = out_neg_r;

  // A miss leaves every result field cleared.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_hit_dist == '0 && out_hit_x == '0 &&
      out_hit_y == '0 && out_hit_z == '0 && out_normal_axis == '0 && !out_normal_negative)
    else $error("miss result carries non-zero fields");

  // Every result transfer traces back to a ray taken earlier, as recorded in vld_s1_r.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(vld_s1_r, OUT_LAT))
    else $error("result transfer without a matching ray");

  // Reset empties the pipeline.
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result transfer straight after reset");

endmodule

`default_nettype wire
